[rtl/mfhp_pkg.sv]
`timescale 1ns / 1ps

package mfhp_pkg;

    localparam int MAGIC_BYTES_DEFAULT = 20;

    // option flag bit positions
    localparam int FLAG_START_POS  = 6;
    localparam int FLAG_START_ZOOM = 5;
    localparam int FLAG_LANGUAGE   = 4;
    localparam int FLAG_COMMENT    = 3;
    localparam int FLAG_AUTHOR     = 2;

    localparam int         VARINT_MORE_BIT    = 7;
    localparam logic [5:0] VARINT_SHIFT_LIMIT = 6'd32;
    localparam logic [5:0] VARINT_SHIFT_STEP  = 6'd7;

    typedef enum logic [4:0] {
        PH_MAGIC      = 5'd0,
        PH_HDR_SIZE   = 5'd1,
        PH_VERSION    = 5'd2,
        PH_FILE_SIZE  = 5'd3,
        PH_DATE       = 5'd4,
        PH_MIN_LAT    = 5'd5,
        PH_MIN_LON    = 5'd6,
        PH_MAX_LAT    = 5'd7,
        PH_MAX_LON    = 5'd8,
        PH_TILE_SIZE  = 5'd9,
        PH_PROJ_LEN   = 5'd10,
        PH_PROJ_CHAR  = 5'd11,
        PH_FLAGS      = 5'd12,
        PH_START_LAT  = 5'd13,
        PH_START_LON  = 5'd14,
        PH_START_ZOOM = 5'd15,
        PH_LANG_LEN   = 5'd16,
        PH_LANG_CHAR  = 5'd17,
        PH_COMM_LEN   = 5'd18,
        PH_COMM_CHAR  = 5'd19,
        PH_AUTH_LEN   = 5'd20,
        PH_AUTH_CHAR  = 5'd21,
        PH_POI_CNT    = 5'd22,
        PH_POI_LEN    = 5'd23,
        PH_POI_CHAR   = 5'd24,
        PH_WAY_CNT    = 5'd25,
        PH_WAY_LEN    = 5'd26,
        PH_WAY_CHAR   = 5'd27,
        PH_DONE       = 5'd28
    } phase_t;

    typedef struct packed {
        phase_t        phase;
        logic [31:0]   byte_counter;
        logic [63:0]   value_accumulator;
        logic [5:0]    varint_shift;
        logic [7:0]    option_flags;
        logic [15:0]   tags_remaining;
        logic [15:0]   tag_position;
    } mfhp_state_t;

    typedef struct packed {
        logic          valid;
        logic [4:0]    code;
        logic [63:0]   value;
        logic [15:0]   index;
        logic          done;
    } mfhp_result_t;

    function automatic logic [3:0] fixed_width(logic [4:0] p);
        logic [3:0] w;
        case (p)
            PH_FILE_SIZE, PH_DATE:               w = 4'd8;
            PH_TILE_SIZE, PH_POI_CNT, PH_WAY_CNT: w = 4'd2;
            PH_FLAGS, PH_START_ZOOM:             w = 4'd1;
            default:                             w = 4'd4;
        endcase
        return w;
    endfunction

    function automatic logic is_len_phase(logic [4:0] p);
        return p == PH_PROJ_LEN || p == PH_LANG_LEN || p == PH_COMM_LEN ||
               p == PH_AUTH_LEN || p == PH_POI_LEN || p == PH_WAY_LEN;
    endfunction

    function automatic logic is_char_phase(logic [4:0] p);
        return p == PH_PROJ_CHAR || p == PH_LANG_CHAR || p == PH_COMM_CHAR ||
               p == PH_AUTH_CHAR || p == PH_POI_CHAR || p == PH_WAY_CHAR;
    endfunction

    // skip over optional fields whose flag is clear
    function automatic phase_t resolve_phase(logic [4:0] target, logic [7:0] flags);
        logic [4:0] p;
        p = target;
        if ((p == PH_START_LAT || p == PH_START_LON) && !flags[FLAG_START_POS])
            p = PH_START_ZOOM;
        if (p == PH_START_ZOOM && !flags[FLAG_START_ZOOM])
            p = PH_LANG_LEN;
        if ((p == PH_LANG_LEN || p == PH_LANG_CHAR) && !flags[FLAG_LANGUAGE])
            p = PH_COMM_LEN;
        if ((p == PH_COMM_LEN || p == PH_COMM_CHAR) && !flags[FLAG_COMMENT])
            p = PH_AUTH_LEN;
        if ((p == PH_AUTH_LEN || p == PH_AUTH_CHAR) && !flags[FLAG_AUTHOR])
            p = PH_POI_CNT;
        return phase_t'(p);
    endfunction

endpackage

[rtl/mfhp_step.sv]
`timescale 1ns / 1ps

module mfhp_step
    import mfhp_pkg::*;
#(
    parameter int MAGIC_BYTES = MAGIC_BYTES_DEFAULT
)
(
    input  mfhp_state_t  cur,
    input  logic [7:0]   data_byte,
    output mfhp_state_t  nxt,
    output mfhp_result_t res
);

    function automatic mfhp_state_t enter_phase(mfhp_state_t s, logic [4:0] target);
        mfhp_state_t r;
        r = s;
        r.phase             = resolve_phase(target, s.option_flags);
        r.byte_counter      = '0;
        r.value_accumulator = '0;
        r.varint_shift      = '0;
        return r;
    endfunction

    // close the string of char phase c
    function automatic mfhp_state_t end_string(mfhp_state_t s, logic [4:0] c);
        mfhp_state_t r;
        r = s;
        if (c == PH_POI_CHAR || c == PH_WAY_CHAR)
        begin
            r.tags_remaining = s.tags_remaining - 16'd1;
            r.tag_position   = s.tag_position + 16'd1;
            if (r.tags_remaining == '0)
                r = enter_phase(r, c + 5'd1);
            else
                r = enter_phase(r, c - 5'd1);
        end
        else
        begin
            r = enter_phase(r, c + 5'd1);
        end
        return r;
    endfunction

    logic [4:0]  p;
    logic [31:0] bc_inc;
    logic [63:0] acc_shift;
    logic [38:0] group;
    logic [31:0] len_acc;
    logic        tag_len;
    logic        tag_char;

    always_comb
    begin
        p         = cur.phase;
        bc_inc    = cur.byte_counter + 32'd1;
        acc_shift = {cur.value_accumulator[55:0], data_byte};
        group     = {32'd0, data_byte[6:0]} << cur.varint_shift;
        // groups at or above bit 32 fall off
        len_acc   = cur.value_accumulator[31:0]
                  | ((cur.varint_shift < VARINT_SHIFT_LIMIT) ? group[31:0] : 32'd0);
        tag_len   = (p == PH_POI_LEN)  || (p == PH_WAY_LEN);
        tag_char  = (p == PH_POI_CHAR) || (p == PH_WAY_CHAR);

        nxt       = cur;
        res       = '0;
        res.code  = p;

        if (p >= PH_DONE)
        begin
            // header finished: ignore everything
        end
        else if (p == PH_MAGIC)
        begin
            res.valid        = 1'b1;
            res.value        = {56'd0, data_byte};
            res.index        = cur.byte_counter[15:0];
            nxt.byte_counter = bc_inc;
            if (bc_inc >= 32'(MAGIC_BYTES))
                nxt = enter_phase(nxt, PH_HDR_SIZE);
        end
        else if (is_len_phase(p))
        begin
            nxt.value_accumulator = {32'd0, len_acc};
            if (data_byte[VARINT_MORE_BIT])
            begin
                if (cur.varint_shift < VARINT_SHIFT_LIMIT)
                    nxt.varint_shift = cur.varint_shift + VARINT_SHIFT_STEP;
            end
            else
            begin
                res.valid = 1'b1;
                res.value = {32'd0, len_acc};
                if (tag_len)
                    res.index = cur.tag_position;
                if (len_acc == '0)
                begin
                    nxt      = end_string(nxt, p + 5'd1);
                    res.done = (p == PH_WAY_LEN) && (cur.tags_remaining == 16'd1);
                end
                else
                begin
                    nxt.phase             = phase_t'(p + 5'd1);
                    nxt.byte_counter      = len_acc;
                    nxt.value_accumulator = '0;
                    nxt.varint_shift      = '0;
                end
            end
        end
        else if (is_char_phase(p))
        begin
            res.valid = 1'b1;
            res.value = {56'd0, data_byte};
            if (tag_char)
                res.index = cur.tag_position;
            if (cur.byte_counter <= 32'd1)
            begin
                nxt      = end_string(cur, p);
                res.done = (p == PH_WAY_CHAR) && (cur.tags_remaining == 16'd1);
            end
            else
            begin
                nxt.byte_counter = cur.byte_counter - 32'd1;
            end
        end
        else
        begin
            // fixed-width big-endian field
            nxt.value_accumulator = acc_shift;
            nxt.byte_counter      = bc_inc;
            if (bc_inc >= {28'd0, fixed_width(p)})
            begin
                res.valid = 1'b1;
                res.value = acc_shift;
                if (p == PH_FLAGS)
                begin
                    nxt.option_flags = data_byte;
                    nxt = enter_phase(nxt, PH_START_LAT);
                end
                else if (p == PH_POI_CNT || p == PH_WAY_CNT)
                begin
                    if (acc_shift[15:0] == '0)
                    begin
                        nxt = enter_phase(nxt, (p == PH_POI_CNT) ? PH_WAY_CNT : PH_DONE);
                        res.done = (p == PH_WAY_CNT);
                    end
                    else
                    begin
                        nxt.tags_remaining = acc_shift[15:0];
                        nxt.tag_position   = '0;
                        nxt = enter_phase(nxt, p + 5'd1);
                    end
                end
                else
                begin
                    nxt = enter_phase(nxt, p + 5'd1);
                end
            end
        end
    end

endmodule

[rtl/map_file_header_parser_core.sv]
`timescale 1ns / 1ps

// Output: a result beat appears the cycle after the byte that completes its field.
// Throughput: one byte per cycle; the parse step is a single pass between the
// state register and the result register, so only out_ready can hold input back.
// Reset: parser returns to the magic phase with all counters and flags cleared,
// and no result is pending.
module map_file_header_parser_core
    import mfhp_pkg::*;
#(
    parameter int MAGIC_BYTES = MAGIC_BYTES_DEFAULT
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  data_byte,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [4:0]  field_code,
    output logic [63:0] field_value,
    output logic [15:0] item_index,
    output logic        header_done
);

    mfhp_state_t  state_reg;
    mfhp_state_t  state_next;
    mfhp_state_t  step_state;
    mfhp_result_t step_res;

    logic         out_valid_reg;
    logic         out_valid_next;
    logic [4:0]   field_code_reg;
    logic [63:0]  field_value_reg;
    logic [15:0]  item_index_reg;
    logic         header_done_reg;
    logic         accept;
    logic         load;

    mfhp_step #(
        .MAGIC_BYTES (MAGIC_BYTES)
    ) u_step (
        .cur       (state_reg),
        .data_byte (data_byte),
        .nxt       (step_state),
        .res       (step_res)
    );

    assign in_ready = !out_valid_reg || out_ready;
    assign accept   = in_valid && in_ready;
    assign load     = accept && step_res.valid;

    always_comb
    begin
        state_next     = accept ? step_state : state_reg;
        out_valid_next = load ? 1'b1 : (out_ready ? 1'b0 : out_valid_reg);
    end

    // all-zero state is the magic phase
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            field_code_reg  <= step_res.code;
            field_value_reg <= step_res.value;
            item_index_reg  <= step_res.index;
            header_done_reg <= step_res.done;
        end
    end

    assign out_valid   = out_valid_reg;
    assign field_code  = field_code_reg;
    assign field_value = field_value_reg;
    assign item_index  = item_index_reg;
    assign header_done = header_done_reg;

`ifndef SYNTHESIS
    a_done_enters_end: assert property (@(posedge clk) disable iff (!rst_n)
        load && step_res.done |=> state_reg.phase == PH_DONE)
        else $error("header completion did not reach end phase");

    a_end_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.phase == PH_DONE |=> state_reg.phase == PH_DONE && !step_res.valid)
        else $error("parser left end phase");

    a_shift_only_in_len: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.varint_shift != '0 |-> is_len_phase(state_reg.phase))
        else $error("varint shift outside a length field");

    a_done_beat_at_end: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && header_done |-> state_reg.phase == PH_DONE)
        else $error("header_done beat while parsing continues");
`endif

endmodule

[bench/map_file_header_parser_core_checker.sv]
`timescale 1ns / 1ps

module map_file_header_parser_core_checker
    import mfhp_pkg::*;
#(
    parameter int MAGIC_BYTES = MAGIC_BYTES_DEFAULT
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_ready,
    input  logic [7:0]  data_byte,
    input  logic        out_valid,
    input  logic        out_ready,
    input  logic [4:0]  field_code,
    input  logic [63:0] field_value,
    input  logic [15:0] item_index,
    input  logic        header_done,
    output int          mismatches,
    output int          fields_pending
);

    localparam int REPORT_LIMIT = 50;

    typedef struct {
        logic [4:0]  code;
        logic [63:0] value;
        logic [15:0] index;
        logic        done;
    } field_beat_t;

    field_beat_t fields_due[$];

    phase_t      cur_phase;
    logic [31:0] run_count;
    logic [63:0] acc_word;
    logic [5:0]  group_shift;
    logic [7:0]  opt_flags;
    logic [15:0] tags_left;
    logic [15:0] tag_no;

    function automatic int field_bytes(input int p);
        case (p)
            PH_FILE_SIZE, PH_DATE:                return 8;
            PH_TILE_SIZE, PH_POI_CNT, PH_WAY_CNT: return 2;
            PH_FLAGS, PH_START_ZOOM:              return 1;
            default:                              return 4;
        endcase
    endfunction

    function automatic bit counts_length(input int p);
        return p == PH_PROJ_LEN || p == PH_LANG_LEN || p == PH_COMM_LEN ||
               p == PH_AUTH_LEN || p == PH_POI_LEN || p == PH_WAY_LEN;
    endfunction

    function automatic bit carries_text(input int p);
        return p == PH_PROJ_CHAR || p == PH_LANG_CHAR || p == PH_COMM_CHAR ||
               p == PH_AUTH_CHAR || p == PH_POI_CHAR || p == PH_WAY_CHAR;
    endfunction

    function automatic bit phase_present(input int p);
        case (p)
            PH_START_LAT, PH_START_LON: return opt_flags[FLAG_START_POS];
            PH_START_ZOOM:              return opt_flags[FLAG_START_ZOOM];
            PH_LANG_LEN, PH_LANG_CHAR:  return opt_flags[FLAG_LANGUAGE];
            PH_COMM_LEN, PH_COMM_CHAR:  return opt_flags[FLAG_COMMENT];
            PH_AUTH_LEN, PH_AUTH_CHAR:  return opt_flags[FLAG_AUTHOR];
            default:                    return 1'b1;
        endcase
    endfunction

    task automatic advance_to(input int target);
        int p;
        p = target;
        while (p < PH_DONE && !phase_present(p))
            p++;
        if (p > PH_DONE)
            p = PH_DONE;
        cur_phase   = phase_t'(p);
        run_count   = '0;
        acc_word    = '0;
        group_shift = '0;
    endtask

    // string of text phase p is over; tag lists loop back to the next length
    task automatic close_text(input int p, output logic fin);
        fin = 1'b0;
        if (p == PH_POI_CHAR || p == PH_WAY_CHAR)
        begin
            tags_left = tags_left - 16'd1;
            tag_no    = tag_no + 16'd1;
            if (tags_left == 16'd0)
            begin
                advance_to(p + 1);
                fin = (p == PH_WAY_CHAR);
            end
            else
            begin
                advance_to(p - 1);
            end
        end
        else
        begin
            advance_to(p + 1);
        end
    endtask

    task automatic decode_byte(input logic [7:0] b);
        int          p;
        logic        emit;
        logic        fin;
        field_beat_t beat;
        p          = cur_phase;
        emit       = 1'b0;
        fin        = 1'b0;
        beat.code  = cur_phase;
        beat.value = '0;
        beat.index = '0;
        beat.done  = 1'b0;
        if (p == PH_DONE)
        begin
            emit = 1'b0;
        end
        else if (p == PH_MAGIC)
        begin
            beat.value = {56'd0, b};
            beat.index = run_count[15:0];
            run_count  = run_count + 32'd1;
            if (run_count >= MAGIC_BYTES)
                advance_to(PH_HDR_SIZE);
            emit = 1'b1;
        end
        else if (counts_length(p))
        begin
            // groups from bit 32 upwards fall off the 32-bit length
            if (group_shift < VARINT_SHIFT_LIMIT)
                acc_word = acc_word | (({57'd0, b[6:0]} << group_shift) & 64'hFFFF_FFFF);
            if (b[VARINT_MORE_BIT])
            begin
                if (group_shift < VARINT_SHIFT_LIMIT)
                    group_shift = group_shift + VARINT_SHIFT_STEP;
            end
            else
            begin
                beat.value = acc_word;
                if (p == PH_POI_LEN || p == PH_WAY_LEN)
                    beat.index = tag_no;
                if (acc_word == 64'd0)
                begin
                    close_text(p + 1, fin);
                    beat.done = fin;
                end
                else
                begin
                    cur_phase   = phase_t'(p + 1);
                    run_count   = acc_word[31:0];
                    acc_word    = '0;
                    group_shift = '0;
                end
                emit = 1'b1;
            end
        end
        else if (carries_text(p))
        begin
            beat.value = {56'd0, b};
            if (p == PH_POI_CHAR || p == PH_WAY_CHAR)
                beat.index = tag_no;
            if (run_count <= 32'd1)
            begin
                close_text(p, fin);
                beat.done = fin;
            end
            else
            begin
                run_count = run_count - 32'd1;
            end
            emit = 1'b1;
        end
        else
        begin
            acc_word  = {acc_word[55:0], b};
            run_count = run_count + 32'd1;
            if (run_count >= field_bytes(p))
            begin
                beat.value = acc_word;
                emit       = 1'b1;
                if (p == PH_FLAGS)
                begin
                    opt_flags = b;
                    advance_to(PH_START_LAT);
                end
                else if (p == PH_POI_CNT || p == PH_WAY_CNT)
                begin
                    if (acc_word[15:0] == 16'd0)
                    begin
                        if (p == PH_POI_CNT)
                        begin
                            advance_to(PH_WAY_CNT);
                        end
                        else
                        begin
                            advance_to(PH_DONE);
                            beat.done = 1'b1;
                        end
                    end
                    else
                    begin
                        tags_left = acc_word[15:0];
                        tag_no    = '0;
                        advance_to(p + 1);
                    end
                end
                else
                begin
                    advance_to(p + 1);
                end
            end
        end
        if (emit)
            fields_due.push_back(beat);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        field_beat_t want;
        logic        bad;
        if (!rst_n)
        begin
            cur_phase      = PH_MAGIC;
            run_count      = '0;
            acc_word       = '0;
            group_shift    = '0;
            opt_flags      = '0;
            tags_left      = '0;
            tag_no         = '0;
            mismatches     = 0;
            fields_pending = 0;
            fields_due.delete();
        end
        else
        begin
            // check the result beat before predicting, so a stray beat cannot
            // pair with the byte taken on the same edge
            if (out_valid && out_ready)
            begin
                if (fields_due.size() == 0)
                begin
                    if (mismatches < REPORT_LIMIT)
                        $error("result beat with nothing expected: field_code %0d, field_value %0h",
                               field_code, field_value);
                    mismatches++;
                end
                else
                begin
                    want = fields_due.pop_front();
                    bad  = 1'b0;
                    if (field_code !== want.code)
                    begin
                        bad = 1'b1;
                        if (mismatches < REPORT_LIMIT)
                            $error("field_code: expected %0d, got %0d", want.code, field_code);
                    end
                    if (field_value !== want.value)
                    begin
                        bad = 1'b1;
                        if (mismatches < REPORT_LIMIT)
                            $error("field_value: expected %0h, got %0h", want.value, field_value);
                    end
                    if (item_index !== want.index)
                    begin
                        bad = 1'b1;
                        if (mismatches < REPORT_LIMIT)
                            $error("item_index: expected %0d, got %0d", want.index, item_index);
                    end
                    if (header_done !== want.done)
                    begin
                        bad = 1'b1;
                        if (mismatches < REPORT_LIMIT)
                            $error("header_done: expected %0b, got %0b", want.done, header_done);
                    end
                    if (bad)
                        mismatches++;
                end
            end
            if (in_valid && in_ready)
                decode_byte(data_byte);
            fields_pending = fields_due.size();
        end
    end

endmodule

[bench/map_file_header_parser_core_tb.sv]
`timescale 1ns / 1ps

module map_file_header_parser_core_tb
    import mfhp_pkg::*;
;

    localparam int MAGIC_LEN     = MAGIC_BYTES_DEFAULT;
    localparam int STREAM_TARGET = 1150;
    localparam int TRAILER_BYTES = 16;
    localparam int CYCLE_LIMIT   = 200000;

    // number fill patterns
    localparam int FILL_ZERO = 0;
    localparam int FILL_ONES = 1;
    localparam int FILL_MIN  = 2;
    localparam int FILL_MAX  = 3;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [7:0]  data_byte;
    logic        out_valid;
    logic        out_ready  = 1'b0;
    logic [4:0]  field_code;
    logic [63:0] field_value;
    logic [15:0] item_index;
    logic        header_done;

    int          mismatches;
    int          fields_pending;
    int          burst_left;
    int          cycle_count;
    logic [15:0] stall_tick = '0;
    logic [7:0]  header_stream[$];

    map_file_header_parser_core #(.MAGIC_BYTES(MAGIC_LEN)) DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .data_byte   (data_byte),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .field_code  (field_code),
        .field_value (field_value),
        .item_index  (item_index),
        .header_done (header_done)
    );

    map_file_header_parser_core_checker #(.MAGIC_BYTES(MAGIC_LEN)) field_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .data_byte      (data_byte),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .field_code     (field_code),
        .field_value    (field_value),
        .item_index     (item_index),
        .header_done    (header_done),
        .mismatches     (mismatches),
        .fields_pending (fields_pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // receiver: free-flowing, coin-toss, mostly stalled, then a fixed repeating ready/stall rhythm
    always @(negedge clk)
    begin
        stall_tick <= stall_tick + 16'd1;
        case (stall_tick[9:8])
            2'd0:    out_ready <= 1'b1;
            2'd1:    out_ready <= ($urandom_range(0, 1) == 0);
            2'd2:    out_ready <= ($urandom_range(0, 3) == 0);
            default: out_ready <= (stall_tick[2:0] < 3'd5);
        endcase
    end

    function automatic int unsigned pick_len();
        int r;
        r = $urandom_range(0, 19);
        if (r < 4)
            return 0;
        if (r == 19)
            return $urandom_range(128, 200);
        return $urandom_range(1, 16);
    endfunction

    task automatic push_number(input int nbytes);
        int         fill;
        logic [7:0] b;
        fill = $urandom_range(0, 5);
        for (int i = 0; i < nbytes; i++)
        begin
            case (fill)
                FILL_ZERO: b = 8'h00;
                FILL_ONES: b = 8'hFF;
                FILL_MIN:  b = (i == 0) ? 8'h80 : 8'h00;
                FILL_MAX:  b = (i == 0) ? 8'h7F : 8'hFF;
                default:   b = 8'($urandom);
            endcase
            header_stream.push_back(b);
        end
    endtask

    // over-long encodings pad with zero groups, then junk that lands past bit 31
    task automatic push_length(input int unsigned len, input bit stretch);
        int         nb;
        int         sh;
        logic [7:0] b;
        nb = 1;
        while ((len >> (7 * nb)) != 0)
            nb++;
        if (stretch)
            nb = 7;
        else if ($urandom_range(0, 3) == 0)
            nb = nb + $urandom_range(1, 7);
        for (int i = 0; i < nb; i++)
        begin
            sh = (i < 5) ? 7 * i : 35;
            if (sh < 28)
                b = 8'((len >> sh) & 32'h7F);
            else if (sh == 28)
                b = 8'($urandom) & 8'h70;
            else
                b = 8'($urandom) & 8'h7F;
            b[VARINT_MORE_BIT] = (i < nb - 1);
            header_stream.push_back(b);
        end
    endtask

    task automatic push_text(input int unsigned len, input bit stretch);
        logic [7:0] b;
        push_length(len, stretch);
        repeat (len)
        begin
            b = 8'($urandom);
            header_stream.push_back(b);
        end
    endtask

    task automatic push_tag_list(input int max_tags, input bit empty_last);
        int unsigned lens[$];
        int          est;
        logic [15:0] tag_total;
        est = header_stream.size();
        while (lens.size() < max_tags && est < STREAM_TARGET)
        begin
            lens.push_back(pick_len());
            est = est + lens[lens.size() - 1] + 1;
        end
        if (empty_last && lens.size() > 0)
            lens[lens.size() - 1] = 0;
        tag_total = 16'(lens.size());
        header_stream.push_back(tag_total[15:8]);
        header_stream.push_back(tag_total[7:0]);
        foreach (lens[k])
            push_text(lens[k], 1'b0);
    endtask

    task automatic build_header();
        logic [7:0] opts;
        logic [7:0] b;
        int         empty_pick;
        bit         poi_empty;
        bit         way_empty;
        for (int i = 0; i < MAGIC_LEN; i++)
        begin
            case (i)
                0:       b = 8'h00;
                1:       b = 8'hFF;
                2:       b = 8'h80;
                3:       b = 8'h7F;
                default: b = 8'($urandom);
            endcase
            header_stream.push_back(b);
        end
        push_number(4);
        push_number(4);
        push_number(8);
        push_number(8);
        repeat (4) push_number(4);
        push_number(2);
        push_text($urandom_range(1, 24), 1'b1);

        // mostly every optional field present; now and then a random mix
        opts = 8'($urandom);
        if ($urandom_range(0, 3) != 0)
            opts[6:2] = 5'b11111;
        header_stream.push_back(opts);
        if (opts[FLAG_START_POS])
        begin
            push_number(4);
            push_number(4);
        end
        if (opts[FLAG_START_ZOOM])
            push_number(1);
        empty_pick = $urandom_range(0, 2);
        if (opts[FLAG_LANGUAGE])
            push_text((empty_pick == 0) ? 0 : pick_len(), 1'b0);
        if (opts[FLAG_COMMENT])
            push_text((empty_pick == 1) ? 0 : pick_len(), 1'b0);
        if (opts[FLAG_AUTHOR])
            push_text((empty_pick == 2) ? 0 : pick_len(), 1'b0);

        poi_empty = ($urandom_range(0, 3) == 0);
        way_empty = !poi_empty && ($urandom_range(0, 4) == 0);
        push_tag_list(poi_empty ? 0 : (way_empty ? 65535 : $urandom_range(1, 24)), 1'b0);
        push_tag_list(way_empty ? 0 : 65535, ($urandom_range(0, 1) == 1));

        // past the end of the header
        repeat (TRAILER_BYTES)
        begin
            b = 8'($urandom);
            header_stream.push_back(b);
        end
    endtask

    task automatic send_byte(input logic [7:0] b);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? $urandom_range(5, 30) : $urandom_range(0, 4);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            burst_left = $urandom_range(1, 48);
        end
        in_valid  <= 1'b1;
        data_byte <= b;
        do
            @(posedge clk);
        while (!in_ready);
        @(negedge clk);
        burst_left--;
    endtask

    initial
    begin
        rst_n      = 1'b0;
        in_valid   = 1'b0;
        data_byte  = 8'h00;
        burst_left = 0;
        build_header();
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        foreach (header_stream[i])
            send_byte(header_stream[i]);
        in_valid <= 1'b0;
        do
            @(negedge clk);
        while (fields_pending != 0);
        repeat (20) @(negedge clk);
        if (mismatches == 0 && fields_pending == 0)
            $display("map_file_header_parser_core regression: pass");
        else
            $display("map_file_header_parser_core regression: fail");
        $finish;
    end

    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("map_file_header_parser_core regression: fail");
        $finish;
    end

endmodule
